FILE: hdl/rsl_pkg.sv
// Package for the record slot table: sizes, request and status codes,
// and the beat and memory structs shared by the table modules.
// No dependencies.
package rsl_pkg;

    localparam int SLOTS   = 16;
    localparam int ID_BITS = 16;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [2:0] REQ_CLEAR  = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_MODIFY = 3'd3;
    localparam logic [2:0] REQ_DELETE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [SLOT_W-1:0]  slot_idx_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] entry_id;
        logic [31:0] salary_bits;
        logic [13:0] sector;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [31:0] result_salary;
        logic [13:0] result_sector;
    } rsp_t;

    typedef struct packed {
        id_t         id;
        logic [31:0] salary;
        logic [13:0] sector;
    } rec_t;

    typedef struct packed {
        logic      rd_en;
        slot_idx_t rd_addr;
        logic      wr_en;
        slot_idx_t wr_addr;
        rec_t      wr_data;
    } mem_req_t;

endpackage

FILE: hdl/rsl_mem.sv
// Record store of the slot table: one write port, one read port,
// registered read data. Depends on rsl_pkg.
module rsl_mem (
    input  logic              clk,
    input  rsl_pkg::mem_req_t mem_req,
    output rsl_pkg::rec_t     rd_data
);
    import rsl_pkg::*;

    rec_t mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rd_data <= mem[mem_req.rd_addr];
        end
    end

endmodule

FILE: hdl/record_slot_table_top.sv
// Top level of the record slot table: request sequencer, valid bits,
// id counter and result register. Depends on rsl_pkg and rsl_mem.
//
// Usage:
//   A request beat on req is taken at a rising edge with start high and
//   busy low. Each request gives exactly one result beat on result, marked
//   by done for one cycle; the receiver cannot stall it.
//   Clear and unknown requests answer in the cycle after the accept and
//   leave busy low, so another request may follow at the next edge.
//   Insert, lookup, modify and delete walk the slots one per cycle through
//   the record memory read port: each slot's record is read and registered,
//   then compared; done is registered from the hit or, on a miss or a full
//   table, from the compare of the last slot. busy stays high for the whole
//   walk, so the next request waits until done; the one-slot-per-cycle
//   walk over the memory sets this.
//   busy is high while a walk is in progress; a new request may be taken in
//   the cycle in which done is high.
//   Reset empties every slot (valid bits clear at once) and zeroes the id
//   counter; record memory contents are not cleared.
module record_slot_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rsl_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output rsl_pkg::rsp_t result
);
    import rsl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    id_t             next_id_reg, next_id_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic            cmp_vld_reg, cmp_vld_next;
    slot_idx_t       cmp_idx_reg, cmp_idx_next;
    req_t            req_reg, req_next;
    logic            done_reg, done_next;
    rsp_t            rsp_reg, rsp_next;

    mem_req_t        mem_req;
    rec_t            rd_data;
    logic            hit;
    logic            walk_end;
    logic            is_insert;
    id_t             key;

    rsl_mem u_mem (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

    assign is_insert = (req_reg.req_type == REQ_INSERT);
    assign key       = ID_BITS'(req_reg.entry_id);
    assign hit       = cmp_vld_reg && (is_insert ? !valid_reg[cmp_idx_reg]
                                                 : (valid_reg[cmp_idx_reg] &&
                                                    rd_data.id == key));
    assign walk_end  = cmp_vld_reg && (cmp_idx_reg == SLOT_W'(SLOTS - 1));

    always_comb
    begin
        state_next   = state_reg;
        valid_next   = valid_reg;
        next_id_next = next_id_reg;
        scan_next    = scan_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        req_next     = req_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    unique case (req.req_type) inside
                        REQ_CLEAR:
                        begin
                            valid_next = '0;
                            done_next  = 1'b1;
                            rsp_next   = '{ST_OK, 16'd0, 32'd0, 14'd0};
                        end
                        REQ_INSERT, REQ_LOOKUP, REQ_MODIFY, REQ_DELETE:
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{ST_OK, 16'd0, 32'd0, 14'd0};
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_reg != CNT_W'(SLOTS))
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = scan_reg[SLOT_W-1:0];
                    cmp_vld_next    = 1'b1;
                    cmp_idx_next    = scan_reg[SLOT_W-1:0];
                    scan_next       = scan_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    state_next   = S_IDLE;
                    cmp_vld_next = 1'b0;
                    done_next    = 1'b1;
                    unique case (req_reg.req_type) inside
                        REQ_INSERT:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = cmp_idx_reg;
                            mem_req.wr_data = '{next_id_reg, req_reg.salary_bits,
                                                req_reg.sector};
                            valid_next[cmp_idx_reg] = 1'b1;
                            next_id_next = next_id_reg + ID_BITS'(1);
                            rsp_next = '{ST_OK, 16'(next_id_reg), req_reg.salary_bits,
                                         req_reg.sector};
                        end
                        REQ_MODIFY:
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = cmp_idx_reg;
                            mem_req.wr_data = '{rd_data.id, req_reg.salary_bits,
                                                req_reg.sector};
                            rsp_next = '{ST_OK, 16'(rd_data.id), req_reg.salary_bits,
                                         req_reg.sector};
                        end
                        REQ_DELETE:
                        begin
                            valid_next[cmp_idx_reg] = 1'b0;
                            rsp_next = '{ST_OK, 16'(rd_data.id), rd_data.salary,
                                         rd_data.sector};
                        end
                        default:
                        begin
                            rsp_next = '{ST_OK, 16'(rd_data.id), rd_data.salary,
                                         rd_data.sector};
                        end
                    endcase
                end
                else if (walk_end)
                begin
                    state_next   = S_IDLE;
                    cmp_vld_next = 1'b0;
                    done_next    = 1'b1;
                    rsp_next     = '{(is_insert ? ST_FULL : ST_NOT_FOUND),
                                     16'd0, 32'd0, 14'd0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            next_id_reg <= '0;
            scan_reg    <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            next_id_reg <= next_id_next;
            scan_reg    <= scan_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        rsp_reg     <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef NO_ASSERTIONS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result beat while a walk is active");

    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> state_reg == S_SCAN)
        else $error("compare stage live outside the walk");

    a_full_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == ST_FULL) |-> (&valid_reg))
        else $error("full reported with a free slot");

    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(next_id_reg) |-> (done_reg && rsp_reg.status == ST_OK))
        else $error("id counter moved without an insert");
`endif

endmodule

FILE: sim/rsl_result_check.sv
// Result checker for the record slot table: keeps its own copy of the slot
// table, predicts one result beat per accepted request and compares it with
// the done beats. Depends on rsl_pkg.
module rsl_result_check (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  rsl_pkg::req_t req,
    input  logic          done,
    input  rsl_pkg::rsp_t result,
    output int            errors,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsl_pkg::*;

    logic        slot_used [SLOTS];
    id_t         slot_key  [SLOTS];
    logic [31:0] slot_pay  [SLOTS];
    logic [13:0] slot_sec  [SLOTS];
    id_t         id_counter;

    rsp_t        awaited_rsp_q [$];
    rsp_t        want;

    function automatic rsp_t slot_view(input int idx);
        rsp_t rsp;
        rsp               = '0;
        rsp.status        = ST_OK;
        rsp.result_id     = 16'(slot_key[idx]);
        rsp.result_salary = slot_pay[idx];
        rsp.result_sector = slot_sec[idx];
        return rsp;
    endfunction

    // applies one request to the shadow table and returns its result beat
    function automatic rsp_t apply_request(input req_t r);
        rsp_t rsp;
        int   hit;
        int   i;
        id_t  key;
        rsp = '0;
        hit = -1;
        key = id_t'(r.entry_id);
        case (r.req_type)
            REQ_CLEAR:
            begin
                for (i = 0; i < SLOTS; i++)
                    slot_used[i] = 1'b0;
            end
            REQ_INSERT:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && !slot_used[i])
                        hit = i;
                if (hit < 0)
                    rsp.status = ST_FULL;
                else
                begin
                    slot_used[hit] = 1'b1;
                    slot_key[hit]  = id_counter;
                    slot_pay[hit]  = r.salary_bits;
                    slot_sec[hit]  = r.sector;
                    id_counter     = id_counter + 1'b1;
                    rsp            = slot_view(hit);
                end
            end
            REQ_LOOKUP, REQ_MODIFY, REQ_DELETE:
            begin
                // lowest matching slot wins when ids repeat
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && slot_used[i] && slot_key[i] == key)
                        hit = i;
                if (hit < 0)
                    rsp.status = ST_NOT_FOUND;
                else
                begin
                    if (r.req_type == REQ_MODIFY)
                    begin
                        slot_pay[hit] = r.salary_bits;
                        slot_sec[hit] = r.sector;
                    end
                    rsp = slot_view(hit);
                    if (r.req_type == REQ_DELETE)
                        slot_used[hit] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] exp_v, got_v);
        $display("%0t ns rsl_result_check: %s mismatch, expected %0h, actual %0h",
                 $time, field, exp_v, got_v);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            id_counter = '0;
            awaited_rsp_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    $display({"%0t ns rsl_result_check: unexpected beat, ",
                              "expected none, actual %h"}, $time, result);
                    errors++;
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    if (result.status !== want.status)
                        flag_field("status", 32'(want.status), 32'(result.status));
                    if (result.result_id !== want.result_id)
                        flag_field("result_id", 32'(want.result_id), 32'(result.result_id));
                    if (result.result_salary !== want.result_salary)
                        flag_field("result_salary", want.result_salary, result.result_salary);
                    if (result.result_sector !== want.result_sector)
                        flag_field("result_sector", 32'(want.result_sector),
                                   32'(result.result_sector));
                end
            end
            if (start && !busy)
                awaited_rsp_q.push_back(apply_request(req));
            pending = awaited_rsp_q.size();
        end
    end

endmodule

FILE: sim/tb_record_slot_table_top.sv
// Testbench top for the record slot table: clock, reset, request stimulus
// with random gaps, and the verdict. Depends on rsl_pkg, rsl_result_check
// and record_slot_table_top.
module tb_record_slot_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsl_pkg::*;

    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;
    localparam int         RANDOM_BEATS     = 1800;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    req_t        req;
    rsp_t        result;
    int          errors;
    int          pending;
    logic [15:0] recent_id;

    record_slot_table_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req    (req),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    rsl_result_check u_result_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(60_000_000);
        $display("tb_record_slot_table_top: errors");
        $finish;
    end

    // most recent live-looking id, used to aim lookups at stored entries
    always @(posedge clk)
    begin
        if (!rst_n)
            recent_id <= '0;
        else if (done && result.status == ST_OK && result.result_id != '0)
            recent_id <= result.result_id;
    end

    function automatic req_t make_req(input logic [2:0] kind, input logic [15:0] id,
                                      input logic [31:0] sal, input logic [13:0] sec);
        req_t r;
        r.req_type    = kind;
        r.entry_id    = id;
        r.salary_bits = sal;
        r.sector      = sec;
        return r;
    endfunction

    function automatic logic [31:0] pick_salary();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [13:0] pick_sector();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 14'd0;
        if (r == 1)
            return 14'd9999;
        if (r == 2)
            return 14'($urandom_range(10000, 16383));
        return 14'($urandom_range(0, 9999));
    endfunction

    function automatic req_t noise_req();
        return make_req(3'($urandom), 16'($urandom), $urandom, 14'($urandom));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one request beat; start stays high when gap is zero
    task automatic send(input req_t r, input int gap);
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            req   <= noise_req();
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] id;
        logic [2:0]  kind;
        int          n;
        int          pick;
        int          wait_cycles;
        bit          calm;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: misses on an empty table, fill to full, hits, extremes
        send(make_req(REQ_CLEAR, 16'($urandom), $urandom, 14'($urandom)), 0);
        send(make_req(REQ_MODIFY, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF), 1);
        send(make_req(REQ_DELETE, 16'h0000, 32'h0, 14'h0), 0);
        send(make_req(REQ_INSERT, 16'hFFFF, 32'h0000_0000, 14'd0), 0);
        send(make_req(REQ_INSERT, 16'h0000, 32'hFFFF_FFFF, 14'h3FFF), 2);
        send(make_req(REQ_INSERT, 16'($urandom), $urandom, 14'd9999), 0);
        for (n = 3; n < SLOTS; n++)
            send(make_req(REQ_INSERT, 16'($urandom), pick_salary(), pick_sector()), n % 3);
        send(make_req(REQ_INSERT, 16'($urandom), 32'hFFFF_FFFF, 14'h3FFF), 0);
        send(make_req(REQ_LOOKUP, 16'(SLOTS - 1), $urandom, 14'($urandom)), 0);
        send(make_req(REQ_LOOKUP, 16'hFFFF, $urandom, 14'($urandom)), 0);
        send(make_req(REQ_MODIFY, 16'd3, 32'hFFFF_FFFF, 14'd0), 0);
        send(make_req(REQ_DELETE, 16'd0, $urandom, 14'($urandom)), 1);
        send(make_req(REQ_INSERT, 16'($urandom), 32'h8000_0001, 14'h2AAA), 0);
        send(make_req(REQ_UNUSED_FIRST, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF), 0);
        send(make_req(REQ_UNUSED_LAST, 16'($urandom), $urandom, 14'($urandom)), 0);

        // random traffic, mostly aimed at ids that are likely stored
        calm = 1'b0;
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 64 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            id   = recent_id - 16'($urandom_range(0, SLOTS + 1));
            if (pick < 30)
                kind = REQ_INSERT;
            else if (pick < 50)
                kind = REQ_LOOKUP;
            else if (pick < 65)
                kind = REQ_MODIFY;
            else if (pick < 85)
                kind = REQ_DELETE;
            else if (pick < 88)
                kind = REQ_CLEAR;
            else if (pick < 90)
                kind = 3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
            else
            begin
                kind = 3'($urandom_range(REQ_LOOKUP, REQ_DELETE));
                id   = 16'($urandom);
            end
            send(make_req(kind, id, pick_salary(), pick_sector()), calm ? 0 : pick_gap());
        end
        start <= 1'b0;

        @(negedge clk);
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 8 * SLOTS + 64)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (2 * SLOTS + 4) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_record_slot_table_top: clean");
        else
            $display("tb_record_slot_table_top: errors");
        $finish;
    end

endmodule
